[sv/pkht_pkg.sv]
// Shared types, codes and constants of the pointer-key hash table.
package pkht_pkg;

   localparam int KEY_BITS    = 64;
   localparam int OP_BITS     = 2;
   localparam int ID_BITS     = 32;
   localparam int STATUS_BITS = 3;

   // key mixer: xor-shift, multiply, xor-shift
   localparam logic [KEY_BITS-1:0] MIX_MULT  = 64'hff51afd7ed558ccd;
   localparam int                  MIX_SHIFT = 33;

   // load limit: a new key is taken only while (occupancy + 1) * LOAD_DEN < slots * LOAD_NUM
   localparam int LOAD_NUM = 3;
   localparam int LOAD_DEN = 4;

   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_UPDATED   = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_CLEARED   = 3'd5;

   // partial product select of the 64-bit multiply
   localparam logic [1:0] MUL_LO_LO = 2'd0;
   localparam logic [1:0] MUL_LO_HI = 2'd1;
   localparam logic [1:0] MUL_HI_LO = 2'd2;

   typedef struct packed {
      logic                   capture;
      logic                   sweep_start;
      logic                   mul_en;
      logic [1:0]             mul_sel;
      logic                   acc_load;
      logic                   acc_add;
      logic                   hash_load;
      logic                   rd_en;
      logic                   advance;
      logic                   wr_slot;
      logic                   occ_inc;
      logic                   sweep_step;
      logic                   occ_clr;
      logic                   rsp_load;
      logic [STATUS_BITS-1:0] rsp_status;
   } pkht_cmd_type;

   typedef struct packed {
      logic slot_valid;
      logic key_match;
      logic probe_last;
      logic load_full;
      logic sweep_last;
      logic rsp_free;
   } pkht_sts_type;

endpackage

[sv/pkht_req_if.sv]
// Request channel: operation, key and id with a valid/ready handshake.
interface pkht_req_if;
   import pkht_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_BITS-1:0]  operation;
   logic [KEY_BITS-1:0] lookup_key;
   logic [ID_BITS-1:0]  entry_value;

   modport source (output valid, output operation, output lookup_key, output entry_value,
                   input ready);
   modport sink (input valid, input operation, input lookup_key, input entry_value,
                 output ready);
endinterface

[sv/pkht_rsp_if.sv]
// Response channel: status and found id with a valid/ready handshake.
interface pkht_rsp_if;
   import pkht_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [ID_BITS-1:0]     found_value;

   modport source (output valid, output status, output found_value, input ready);
   modport sink (input valid, input status, input found_value, output ready);
endinterface

[sv/pkht_datapath.sv]
// Hash table datapath: key mixer, slot memory, probe index, occupancy and response register.
module pkht_datapath #(
   parameter int TABLE_SLOTS = 1024,
   parameter int VALUE_BITS  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pkht_pkg::pkht_cmd_type               cmd,
   input  logic [pkht_pkg::KEY_BITS-1:0]        key_in,
   input  logic [pkht_pkg::ID_BITS-1:0]         value_in,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [pkht_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [pkht_pkg::ID_BITS-1:0]         rsp_found_value,
   output pkht_pkg::pkht_sts_type               sts
);
   import pkht_pkg::*;

   localparam int IW    = $clog2(TABLE_SLOTS);
   localparam int OW    = IW + 1;
   localparam int LW    = IW + 3;
   localparam int MEM_W = 1 + KEY_BITS + VALUE_BITS;
   localparam logic [IW-1:0] LAST_IDX   = IW'(TABLE_SLOTS - 1);
   localparam logic [LW-1:0] LOAD_LIMIT = LW'(LOAD_NUM * TABLE_SLOTS);

   logic [MEM_W-1:0] slot_mem [TABLE_SLOTS];

   logic [KEY_BITS-1:0]   key_ff, key_in_d;
   logic [VALUE_BITS-1:0] val_ff;
   logic [KEY_BITS-1:0]   mix_ff, mix_in;
   logic [63:0]           prod_ff, prod_in;
   logic [31:0]           mul_a, mul_b;
   logic [KEY_BITS-1:0]   acc_ff, acc_in;
   logic [KEY_BITS-1:0]   hash_mix;
   logic [IW-1:0]         idx_ff, idx_in, idx_next;
   logic [IW-1:0]         cnt_ff, cnt_in;
   logic [OW-1:0]         occ_ff, occ_in;
   logic [LW-1:0]         occ_scaled;
   logic [MEM_W-1:0]      rdata_ff;
   logic                  mem_we;
   logic [MEM_W-1:0]      mem_wdata;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [ID_BITS-1:0]    rsp_value_ff, rsp_value_in;
   logic                  rd_valid;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;

   assign key_in_d = key_in;
   assign mix_in   = key_in ^ (key_in >> MIX_SHIFT);

   // one 32x32 partial product per cycle; the high-by-high term falls out of the low 64 bits
   always_comb begin
      mul_a = mix_ff[31:0];
      mul_b = MIX_MULT[31:0];
      case (cmd.mul_sel)
         MUL_LO_LO: begin
            mul_a = mix_ff[31:0];
            mul_b = MIX_MULT[31:0];
         end
         MUL_LO_HI: begin
            mul_a = mix_ff[31:0];
            mul_b = MIX_MULT[63:32];
         end
         MUL_HI_LO: begin
            mul_a = mix_ff[63:32];
            mul_b = MIX_MULT[31:0];
         end
         default: begin
            mul_a = mix_ff[31:0];
            mul_b = MIX_MULT[31:0];
         end
      endcase
   end

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_load) begin
         acc_in = prod_ff;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + {prod_ff[31:0], 32'b0};
      end
   end

   assign hash_mix = acc_ff ^ (acc_ff >> MIX_SHIFT);
   assign idx_next = (idx_ff == LAST_IDX) ? '0 : idx_ff + IW'(1);

   always_comb begin
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      if (cmd.sweep_start) begin
         idx_in = '0;
      end else if (cmd.hash_load) begin
         idx_in = IW'(hash_mix & 64'(TABLE_SLOTS - 1));
         cnt_in = '0;
      end else if (cmd.advance || cmd.sweep_step) begin
         idx_in = idx_next;
         cnt_in = cnt_ff + IW'(1);
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.occ_clr) begin
         occ_in = '0;
      end else if (cmd.occ_inc) begin
         occ_in = occ_ff + OW'(1);
      end
   end

   assign occ_scaled = (LW'(occ_ff) + LW'(1)) * LW'(LOAD_DEN);

   assign mem_we    = cmd.wr_slot || cmd.sweep_step;
   assign mem_wdata = cmd.sweep_step ? '0 : {1'b1, key_ff, val_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[idx_ff] <= mem_wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= slot_mem[idx_ff];
      end
   end

   assign rd_valid = rdata_ff[MEM_W-1];
   assign rd_key   = rdata_ff[VALUE_BITS +: KEY_BITS];
   assign rd_val   = rdata_ff[VALUE_BITS-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_value_in = (cmd.rsp_status == ST_FOUND) ? ID_BITS'(rd_val) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         cnt_ff       <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff <= key_in_d;
         val_ff <= VALUE_BITS'(value_in);
         mix_ff <= mix_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;

   assign sts.slot_valid = rd_valid;
   assign sts.key_match  = rd_key == key_ff;
   assign sts.probe_last = cnt_ff == LAST_IDX;
   assign sts.load_full  = occ_scaled >= LOAD_LIMIT;
   assign sts.sweep_last = idx_ff == LAST_IDX;
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

[sv/pkht_controller.sv]
// Hash table controller: sequences hashing, probing, clearing and the response.
module pkht_controller (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [pkht_pkg::OP_BITS-1:0]   req_op,
   output logic                           req_ready,
   output pkht_pkg::pkht_cmd_type         cmd,
   input  pkht_pkg::pkht_sts_type         sts
);
   import pkht_pkg::*;

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_MUL0  = 4'd2;
   localparam logic [3:0] S_MUL1  = 4'd3;
   localparam logic [3:0] S_MUL2  = 4'd4;
   localparam logic [3:0] S_MUL3  = 4'd5;
   localparam logic [3:0] S_HASH  = 4'd6;
   localparam logic [3:0] S_READ  = 4'd7;
   localparam logic [3:0] S_CHECK = 4'd8;
   localparam logic [3:0] S_CLEAR = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0]             state_ff, state_in;
   logic [OP_BITS-1:0]     op_ff, op_in;
   logic [STATUS_BITS-1:0] result_ff, result_in;
   logic                   is_lookup;

   assign req_ready = state_ff == S_IDLE;
   assign is_lookup = op_ff == OP_LOOKUP;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      result_in = result_ff;
      cmd       = '0;
      case (state_ff)
         S_INIT: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               cmd.occ_clr = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = req_op;
               case (req_op)
                  OP_INSERT, OP_LOOKUP: state_in = S_MUL0;
                  OP_CLEAR: begin
                     cmd.sweep_start = 1'b1;
                     state_in        = S_CLEAR;
                  end
                  default: begin
                     result_in = ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end
         S_MUL0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LO_LO;
            state_in    = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_LO_HI;
            cmd.acc_load = 1'b1;
            state_in     = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_HI_LO;
            cmd.acc_add = 1'b1;
            state_in    = S_MUL3;
         end
         S_MUL3: begin
            cmd.acc_add = 1'b1;
            state_in    = S_HASH;
         end
         S_HASH: begin
            cmd.hash_load = 1'b1;
            state_in      = S_READ;
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_DONE;
            if (!sts.slot_valid) begin
               if (is_lookup) begin
                  result_in = ST_NOT_FOUND;
               end else if (sts.load_full) begin
                  result_in = ST_FULL;
               end else begin
                  cmd.wr_slot = 1'b1;
                  cmd.occ_inc = 1'b1;
                  result_in   = ST_INSERTED;
               end
            end else if (sts.key_match) begin
               if (is_lookup) begin
                  result_in = ST_FOUND;
               end else begin
                  cmd.wr_slot = 1'b1;
                  result_in   = ST_UPDATED;
               end
            end else if (sts.probe_last) begin
               result_in = is_lookup ? ST_NOT_FOUND : ST_FULL;
            end else begin
               // occupied by another key: advance to the next slot
               cmd.advance = 1'b1;
               state_in    = S_READ;
            end
         end
         S_CLEAR: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               cmd.occ_clr = 1'b1;
               result_in   = ST_CLEARED;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            // hold the result until the response register frees up
            if (sts.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = result_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         op_ff     <= OP_INSERT;
         result_ff <= ST_NOT_FOUND;
      end else begin
         state_ff  <= state_in;
         op_ff     <= op_in;
         result_ff <= result_in;
      end
   end

endmodule

[sv/pointer_key_hash_table.sv]
// Pointer-key hash table: 64-bit keys to ids, open addressing with linear probing.
//
// req_chan carries one request per transfer: operation (insert or update, lookup,
// clear), lookup_key and entry_value. rsp_chan returns exactly one status and
// found_value per request, in order. Requests are worked one at a time.
// Insert and lookup: the key mixer steps through S_MUL0, S_MUL1, S_MUL2 and
// S_MUL3 on one shared 32x32 multiplier, then each probed slot is a registered
// read of the single-port slot memory (S_READ), then a compare (S_CHECK). The
// response is loaded in S_DONE once the output register is free, and the
// controller then returns to S_IDLE, where the next request is taken.
// Clear sweeps every slot, one per cycle, then its response goes out through S_DONE.
// After reset the same sweep runs with req_chan.ready low.
// A stalled response sits in the output register; the next request may still
// be worked, and only its own response waits for the register to drain.
module pointer_key_hash_table #(
   parameter int TABLE_SLOTS = 1024,
   parameter int VALUE_BITS  = 32
) (
   input logic      clock,
   input logic      reset,
   pkht_req_if.sink   req_chan,
   pkht_rsp_if.source rsp_chan
);
   import pkht_pkg::*;

   pkht_cmd_type cmd;
   pkht_sts_type sts;

   pkht_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.operation),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   pkht_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .key_in          (req_chan.lookup_key),
      .value_in        (req_chan.entry_value),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_status      (rsp_chan.status),
      .rsp_found_value (rsp_chan.found_value),
      .sts             (sts)
   );

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_chan.valid && !rsp_chan.ready))
      else $error("response overwritten while stalled");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_slot && cmd.sweep_step))
      else $error("slot write and sweep collide");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while busy");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.occ_inc |-> (!sts.slot_valid && !sts.load_full))
      else $error("insert past load limit or into used slot");
`endif

endmodule

[sim/pointer_key_hash_table_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the pointer-key hash table with a tracking scoreboard.

module pointer_key_hash_table_tb;
   import pkht_pkg::*;

   localparam int                 TABLE_SLOTS = 1024;
   localparam int                 VALUE_BITS  = 32;
   localparam logic [OP_BITS-1:0] OP_UNUSED   = 2'd3;
   localparam int                 STALL_LIMIT = 8 * TABLE_SLOTS + 200;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [ID_BITS-1:0]     found_value;
   } table_reply_type;

   // Tracks the table contents and the replies still owed by the block.
   class hash_table_tracker #(int SLOTS = 1024, int VBITS = 32);
      bit                  slot_used[SLOTS];
      logic [KEY_BITS-1:0] slot_key[SLOTS];
      logic [VBITS-1:0]    slot_id[SLOTS];
      int unsigned         occupancy;
      table_reply_type     pending_replies[$];
      int unsigned         bad_replies;
      int unsigned         reply_count;

      function new();
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         occupancy       = 0;
         bad_replies     = 0;
         reply_count     = 0;
      endfunction

      function int unsigned home_of(logic [KEY_BITS-1:0] key);
         logic [KEY_BITS-1:0] x;
         x = key ^ (key >> MIX_SHIFT);
         x = x * MIX_MULT;
         x = x ^ (x >> MIX_SHIFT);
         return int'(x & KEY_BITS'(SLOTS - 1));
      endfunction

      // Walk from the home slot; stop at the key or at the first free slot.
      function bit locate(logic [KEY_BITS-1:0] key, output int unsigned pos);
         int unsigned i;
         i   = home_of(key);
         pos = SLOTS;
         for (int n = 0; n < SLOTS; n++) begin
            if (!slot_used[i]) begin
               pos = i;
               return 1'b0;
            end
            if (slot_key[i] == key) begin
               pos = i;
               return 1'b1;
            end
            i = (i + 1 >= SLOTS) ? 0 : i + 1;
         end
         return 1'b0;
      endfunction

      function logic [STATUS_BITS-1:0] take_request(logic [OP_BITS-1:0] op,
                                                    logic [KEY_BITS-1:0] key,
                                                    logic [ID_BITS-1:0] id);
         table_reply_type want;
         int unsigned     pos;
         bit              hit;
         want.status      = ST_NOT_FOUND;
         want.found_value = '0;
         case (op)
            OP_INSERT: begin
               hit = locate(key, pos);
               if (hit) begin
                  slot_id[pos] = VBITS'(id);
                  want.status  = ST_UPDATED;
               end else if ((occupancy + 1) * LOAD_DEN >= SLOTS * LOAD_NUM
                            || pos >= SLOTS) begin
                  want.status = ST_FULL;
               end else begin
                  slot_used[pos] = 1'b1;
                  slot_key[pos]  = key;
                  slot_id[pos]   = VBITS'(id);
                  occupancy++;
                  want.status = ST_INSERTED;
               end
            end
            OP_LOOKUP: begin
               hit = locate(key, pos);
               if (hit) begin
                  want.status      = ST_FOUND;
                  want.found_value = ID_BITS'(slot_id[pos]);
               end
            end
            OP_CLEAR: begin
               foreach (slot_used[i]) slot_used[i] = 1'b0;
               occupancy   = 0;
               want.status = ST_CLEARED;
            end
            default: ;
         endcase
         pending_replies.push_back(want);
         return want.status;
      endfunction

      function void check_reply(logic [STATUS_BITS-1:0] status, logic [ID_BITS-1:0] found);
         table_reply_type want;
         reply_count++;
         if (pending_replies.size() == 0) begin
            bad_replies++;
            if (bad_replies <= 10)
               $display("reply %0d: none outstanding, got status %0d id %h",
                        reply_count, status, found);
            return;
         end
         want = pending_replies.pop_front();
         if (status !== want.status || found !== want.found_value) begin
            bad_replies++;
            if (bad_replies <= 10)
               $display("reply %0d: status exp %0d got %0d, id exp %h got %h", reply_count,
                        want.status, status, want.found_value, found);
         end
      endfunction

      function int unsigned outstanding();
         return pending_replies.size();
      endfunction

      function bit failed();
         return bad_replies != 0 || pending_replies.size() != 0;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   pkht_req_if req_chan ();
   pkht_rsp_if rsp_chan ();

   pointer_key_hash_table #(
      .TABLE_SLOTS(TABLE_SLOTS),
      .VALUE_BITS (VALUE_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   hash_table_tracker #(TABLE_SLOTS, VALUE_BITS) tracker;
   logic [KEY_BITS-1:0] present_keys[$];
   bit                  req_steady = 1'b0;
   bit                  rsp_steady = 1'b0;
   int                  stall_cycles = 0;

   always #10 clock = ~clock;

   // Per-item wait, with occasional runs of back-to-back transfers.
   function automatic int pace(inout bit steady);
      if ($urandom_range(0, 19) == 0) steady = !steady;
      return steady ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic logic [KEY_BITS-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [KEY_BITS-1:0] known_key();
      if (present_keys.size() == 0) return random_key();
      return present_keys[$urandom_range(0, present_keys.size() - 1)];
   endfunction

   task automatic send_request(input logic [OP_BITS-1:0] op, input logic [KEY_BITS-1:0] key,
                               input logic [ID_BITS-1:0] id);
      int                     gap;
      logic [STATUS_BITS-1:0] outcome;
      gap = pace(req_steady);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.operation   <= op;
      req_chan.lookup_key  <= key;
      req_chan.entry_value <= id;
      do @(posedge clock); while (!req_chan.ready);
      outcome = tracker.take_request(op, key, id);
      if (outcome == ST_INSERTED) present_keys.push_back(key);
      else if (outcome == ST_CLEARED) present_keys.delete();
   endtask

   initial begin
      req_chan.valid       <= 1'b0;
      req_chan.operation   <= OP_LOOKUP;
      req_chan.lookup_key  <= '0;
      req_chan.entry_value <= '0;
      rsp_chan.ready       <= 1'b0;
   end

   // Reply side: random stalls, check each transfer against the oldest expectation.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = pace(rsp_steady);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         tracker.check_reply(rsp_chan.status, rsp_chan.found_value);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("pointer_key_hash_table: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [KEY_BITS-1:0] wrap_keys[$];
      logic [KEY_BITS-1:0] k;
      int                  round_len[3];
      int                  insert_pct[3];
      int                  pick;

      tracker = new();
      round_len  = '{250, 1000, 250};
      insert_pct = '{35, 80, 35};

      // keys whose home is the last slot, so their probes wrap to slot zero
      while (wrap_keys.size() < 4) begin
         k = random_key();
         if (tracker.home_of(k) == TABLE_SLOTS - 1) wrap_keys.push_back(k);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, key and id extremes, update, unused code, wrap, clear
      send_request(OP_LOOKUP, '0, '0);
      send_request(OP_INSERT, '0, '0);
      send_request(OP_INSERT, '1, '1);
      send_request(OP_LOOKUP, '0, '1);
      send_request(OP_LOOKUP, '1, '0);
      send_request(OP_INSERT, '0, 32'ha5a5a5a5);
      send_request(OP_LOOKUP, '0, '0);
      send_request(OP_UNUSED, '1, '1);
      send_request(OP_INSERT, wrap_keys[0], 32'h00000001);
      send_request(OP_INSERT, wrap_keys[1], 32'h80000000);
      send_request(OP_INSERT, wrap_keys[2], 32'h5a5a5a5a);
      send_request(OP_LOOKUP, wrap_keys[2], '0);
      send_request(OP_LOOKUP, wrap_keys[1], '0);
      send_request(OP_LOOKUP, wrap_keys[0], '0);
      send_request(OP_LOOKUP, wrap_keys[3], '0);
      send_request(OP_INSERT, wrap_keys[1], 32'h7fffffff);
      send_request(OP_LOOKUP, wrap_keys[1], '0);
      send_request(OP_CLEAR, '1, '1);
      send_request(OP_LOOKUP, '1, '0);
      send_request(OP_LOOKUP, wrap_keys[2], '0);
      send_request(OP_INSERT, wrap_keys[3], '1);
      send_request(OP_LOOKUP, wrap_keys[3], '0);

      // random rounds; the middle one fills the table up to its load limit
      for (int r = 0; r < 3; r++) begin
         for (int n = 0; n < round_len[r]; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < insert_pct[r])
               send_request(OP_INSERT, random_key(), $urandom);
            else if (pick < insert_pct[r] + 10)
               send_request(OP_INSERT, known_key(), $urandom);
            else if (pick < insert_pct[r] + 40 && pick < 96)
               send_request(OP_LOOKUP, known_key(), $urandom);
            else if (pick < 97)
               send_request(OP_LOOKUP, random_key(), $urandom);
            else if (pick < 99 || r == 1)
               send_request(OP_UNUSED, random_key(), $urandom);
            else
               send_request(OP_CLEAR, random_key(), $urandom);
         end
         send_request(OP_CLEAR, random_key(), $urandom);
      end
      req_chan.valid <= 1'b0;

      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (TABLE_SLOTS + 16) @(posedge clock);
      if (tracker.failed())
         $display("pointer_key_hash_table: mismatch");
      else
         $display("pointer_key_hash_table: match");
      $finish;
   end
endmodule
